### hdl/vmm_pkg.sv
// shared types and constants for the video memory map
package vmm_pkg;

    localparam int PATTERN_BYTES = 8192;
    localparam int NT_BYTES      = 2048;
    localparam int PAL_ENTRIES   = 32;

    localparam int ADDR_W  = 14;
    localparam int DATA_W  = 8;
    localparam int PAL_W   = 6;
    localparam int PAT_AW  = $clog2(PATTERN_BYTES);
    localparam int NT_AW   = $clog2(NT_BYTES);
    localparam int PAL_AW  = $clog2(PAL_ENTRIES);

    // access kinds
    typedef enum logic [1:0] {
        KIND_READ    = 2'd0,
        KIND_WRITE   = 2'd1,
        KIND_PRELOAD = 2'd2
    } kind_t;

    // nametable mirroring modes
    typedef enum logic [1:0] {
        MIRROR_HORIZONTAL  = 2'd0,
        MIRROR_VERTICAL    = 2'd1,
        MIRROR_FOUR_SCREEN = 2'd2
    } mirror_t;

    // configuration register indexes
    localparam int CFG_IDX_W = 1;
    localparam int CFG_DATA_W = 2;
    localparam logic [CFG_IDX_W-1:0] CFG_MIRROR_MODE      = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_PATTERN_WRITABLE = 1'b1;

    // where the result byte of a beat comes from
    typedef enum logic [1:0] {
        SRC_ZERO      = 2'd0,
        SRC_PATTERN   = 2'd1,
        SRC_NAMETABLE = 2'd2,
        SRC_PALETTE   = 2'd3
    } src_t;

endpackage

### hdl/vmm_access_if.sv
// channel interfaces for access beats and result beats
interface vmm_access_if
    import vmm_pkg::*;
();
    logic              valid;
    logic              ready;
    logic [1:0]        kind;
    logic [ADDR_W-1:0] address;
    logic [DATA_W-1:0] write_data;

    modport source (output valid, output kind, output address, output write_data,
                    input ready);
    modport sink   (input valid, input kind, input address, input write_data,
                    output ready);
endinterface

interface vmm_result_if
    import vmm_pkg::*;
();
    logic              valid;
    logic              ready;
    logic [DATA_W-1:0] read_data;

    modport source (output valid, output read_data, input ready);
    modport sink   (input valid, input read_data, output ready);
endinterface

### hdl/vmm_ram.sv
// generic single-port ram with registered read
module vmm_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     clk,
    input  logic                     en,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] addr,
    input  logic [WIDTH-1:0]         wdata,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            if (we)
            begin
                mem[addr] <= wdata;
            end
            else
            begin
                rdata_reg <= mem[addr];
            end
        end
    end

    assign rdata = rdata_reg;

endmodule

### hdl/video_memory_map_mirroring_top.sv
// top level of the video memory map with nametable mirroring
//
// serves one video-bus access beat per cycle once the clearing pass is over, while the
// result side keeps taking results: reads, writes and pattern preloads all sustain one
// beat per clock, and every beat gives exactly one result beat (the byte read, or zero
// for writes and preloads). a result passes the read stage and then the output register
// once its access beat is taken; the pattern and nametable rams have registered reads.
// after reset the block zeroes the 2048 nametable entries, one per cycle, and takes no
// access beat meanwhile; configuration writes are taken at any time. the pattern store
// has no defined content until written. the 32 palette entries sit in flip-flops.
module video_memory_map_mirroring_top
    import vmm_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    vmm_access_if.sink            access,
    vmm_result_if.source          result,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    // configuration
    logic [1:0] mirror_mode_reg;
    logic       pattern_writable_reg;

    // nametable clearing pass
    logic             clear_busy_reg;
    logic [NT_AW-1:0] clear_cnt_reg;

    // palette entries
    logic [PAL_W-1:0] palette_reg [PAL_ENTRIES];

    // read stage (ram data lands here) and output register
    logic              s1_valid_reg;
    src_t              s1_src_reg;
    logic [PAL_W-1:0]  s1_pal_reg;
    logic              out_valid_reg;
    logic [DATA_W-1:0] out_data_reg;

    logic s1_adv;
    logic accept;

    // decode of the incoming beat
    logic              is_write;
    logic              in_pattern;
    logic              in_palette;
    logic              in_nametable;
    logic              pat_write_ok;
    logic [NT_AW-1:0]  nt_index;
    logic [PAL_AW-1:0] pal_index;
    logic              nt_bank;
    src_t              src_next;

    // ram ports
    logic              pat_en;
    logic              pat_we;
    logic [DATA_W-1:0] pat_rdata;
    logic              nt_en;
    logic              nt_we;
    logic [NT_AW-1:0]  nt_addr;
    logic [DATA_W-1:0] nt_wdata;
    logic [DATA_W-1:0] nt_rdata;

    logic [DATA_W-1:0] s1_byte;

    // a held result frees the read stage only when it moves on
    assign s1_adv       = !out_valid_reg || result.ready;
    assign access.ready = !clear_busy_reg && (!s1_valid_reg || s1_adv);
    assign accept       = access.valid && access.ready;

    always_comb
    begin
        is_write     = (access.kind == KIND_WRITE) || (access.kind == KIND_PRELOAD);
        in_pattern   = !access.address[ADDR_W-1];
        in_palette   = (access.address[ADDR_W-1:8] == 6'h3F);
        in_nametable = !in_pattern && !in_palette;
        pat_write_ok = (access.kind == KIND_PRELOAD)
                       || ((access.kind == KIND_WRITE) && pattern_writable_reg);

        // nametable fold: screen in bits 11:10, offset in bits 9:0
        case (mirror_mode_reg)
            MIRROR_HORIZONTAL:  nt_bank = access.address[11];
            MIRROR_VERTICAL:    nt_bank = access.address[10];
            MIRROR_FOUR_SCREEN: nt_bank = access.address[10];
            default:            nt_bank = access.address[10];
        endcase
        nt_index = {nt_bank, access.address[9:0]};

        // palette fold: backdrop mirrors at 0x10, 0x14, 0x18, 0x1c
        pal_index = access.address[PAL_AW-1:0];
        if (pal_index[4] && (pal_index[1:0] == 2'b00))
        begin
            pal_index[4] = 1'b0;
        end

        if (is_write)
        begin
            src_next = SRC_ZERO;
        end
        else if (in_pattern)
        begin
            src_next = SRC_PATTERN;
        end
        else if (in_palette)
        begin
            src_next = SRC_PALETTE;
        end
        else
        begin
            src_next = SRC_NAMETABLE;
        end
    end

    // pattern store
    assign pat_we = is_write;
    assign pat_en = accept && in_pattern && (!is_write || pat_write_ok);

    vmm_ram #(
        .WIDTH (DATA_W),
        .DEPTH (PATTERN_BYTES)
    ) u_pattern_ram (
        .clk   (clk),
        .en    (pat_en),
        .we    (pat_we),
        .addr  (access.address[PAT_AW-1:0]),
        .wdata (access.write_data),
        .rdata (pat_rdata)
    );

    // nametable ram, shared with the clearing pass
    always_comb
    begin
        if (clear_busy_reg)
        begin
            nt_en    = 1'b1;
            nt_we    = 1'b1;
            nt_addr  = clear_cnt_reg;
            nt_wdata = '0;
        end
        else
        begin
            nt_en    = accept && in_nametable;
            nt_we    = is_write;
            nt_addr  = nt_index;
            nt_wdata = access.write_data;
        end
    end

    vmm_ram #(
        .WIDTH (DATA_W),
        .DEPTH (NT_BYTES)
    ) u_nametable_ram (
        .clk   (clk),
        .en    (nt_en),
        .we    (nt_we),
        .addr  (nt_addr),
        .wdata (nt_wdata),
        .rdata (nt_rdata)
    );

    // configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mirror_mode_reg      <= MIRROR_HORIZONTAL;
            pattern_writable_reg <= 1'b0;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_MIRROR_MODE:      mirror_mode_reg      <= cfg_data;
                CFG_PATTERN_WRITABLE: pattern_writable_reg <= cfg_data[0];
                default:              ;
            endcase
        end
    end

    // clearing pass sweeps every nametable entry once after reset
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clear_busy_reg <= 1'b1;
            clear_cnt_reg  <= '0;
        end
        else if (clear_busy_reg)
        begin
            clear_cnt_reg <= clear_cnt_reg + 1'b1;
            if (clear_cnt_reg == NT_AW'(NT_BYTES - 1))
            begin
                clear_busy_reg <= 1'b0;
            end
        end
    end

    // palette entries, only the low six bits are kept
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < PAL_ENTRIES; i++)
            begin
                palette_reg[i] <= '0;
            end
        end
        else if (accept && in_palette && is_write)
        begin
            palette_reg[pal_index] <= access.write_data[PAL_W-1:0];
        end
    end

    // read stage
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (accept)
        begin
            s1_valid_reg <= 1'b1;
        end
        else if (s1_adv)
        begin
            s1_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_src_reg <= src_next;
            s1_pal_reg <= palette_reg[pal_index];
        end
    end

    // pick the result byte; ram data holds while no new read is issued
    always_comb
    begin
        case (s1_src_reg)
            SRC_PATTERN:   s1_byte = pat_rdata;
            SRC_NAMETABLE: s1_byte = nt_rdata;
            SRC_PALETTE:   s1_byte = {{(DATA_W-PAL_W){1'b0}}, s1_pal_reg};
            default:       s1_byte = '0;
        endcase
    end

    // output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (s1_adv)
        begin
            out_valid_reg <= s1_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_adv && s1_valid_reg)
        begin
            out_data_reg <= s1_byte;
        end
    end

    assign result.valid     = out_valid_reg;
    assign result.read_data = out_data_reg;

endmodule

### tb/tb_video_memory_map_mirroring_top.sv
// self-checking testbench for the video memory map with nametable mirroring
module tb_video_memory_map_mirroring_top;
    import vmm_pkg::*;

    // codes the package leaves unnamed: kind 3 reads, mirror mode 3 acts as vertical
    localparam logic [1:0] KIND_SPARE   = 2'd3;
    localparam logic [1:0] MIRROR_SPARE = 2'd3;

    localparam int IDLE_LIMIT  = 10000; // covers the whole clearing pass after reset
    localparam int HOLD_CYCLES = 400;   // long result-side hold-off, well over the pipe depth
    localparam int SETTLE      = 6;     // result passes the read stage and output register after its access beat
    localparam int PHASES      = 6;
    localparam int PER_PHASE   = 138;

    localparam logic [10:0] STALL_PATTERN = 11'b10110111011;

    // map settings per random phase, extremes and the spare mirror mode included
    localparam logic [1:0] PHASE_MIRROR   [PHASES] = '{MIRROR_VERTICAL, MIRROR_FOUR_SCREEN,
                                                       MIRROR_SPARE, MIRROR_HORIZONTAL,
                                                       MIRROR_FOUR_SCREEN, MIRROR_VERTICAL};
    localparam logic       PHASE_WRITABLE [PHASES] = '{1'b1, 1'b0, 1'b1, 1'b1, 1'b0, 1'b1};
    localparam int         HOLD_PHASE = 2;

    typedef struct packed {
        logic [1:0]        kind;
        logic [ADDR_W-1:0] addr;
        logic [DATA_W-1:0] data;
        logic              pinned;  // answer typed in below instead of predicted
        logic [DATA_W-1:0] answer;
    } access_row_t;

    localparam int DIRECTED_ROWS = 25;

    // directed part, run with horizontal mirroring and a read-only pattern store
    localparam access_row_t DIRECTED [DIRECTED_ROWS] = '{
        '{KIND_READ,    14'h2000, 8'h00, 1'b1, 8'h00},  // nametable is zero after reset
        '{KIND_READ,    14'h3EFF, 8'h00, 1'b1, 8'h00},
        '{KIND_READ,    14'h3F00, 8'h00, 1'b1, 8'h00},  // palette is zero after reset
        '{KIND_SPARE,   14'h3FFF, 8'h00, 1'b1, 8'h00},  // unused kind reads
        '{KIND_PRELOAD, 14'h0000, 8'hFF, 1'b1, 8'h00},
        '{KIND_PRELOAD, 14'h1FFF, 8'hA5, 1'b1, 8'h00},
        '{KIND_READ,    14'h0000, 8'h00, 1'b1, 8'hFF},
        '{KIND_READ,    14'h1FFF, 8'h00, 1'b1, 8'hA5},
        '{KIND_WRITE,   14'h0000, 8'h11, 1'b1, 8'h00},  // pattern store is read-only here
        '{KIND_READ,    14'h0000, 8'h00, 1'b1, 8'hFF},
        '{KIND_WRITE,   14'h2000, 8'hFF, 1'b1, 8'h00},
        '{KIND_READ,    14'h2400, 8'h00, 1'b1, 8'hFF},  // horizontal: screens 0 and 1 share
        '{KIND_READ,    14'h2800, 8'h00, 1'b1, 8'h00},
        '{KIND_SPARE,   14'h2400, 8'h00, 1'b0, 8'h00},
        '{KIND_WRITE,   14'h3F10, 8'hFF, 1'b1, 8'h00},  // aliased entry, six bits kept
        '{KIND_READ,    14'h3F00, 8'h00, 1'b1, 8'h3F},
        '{KIND_READ,    14'h3F10, 8'h00, 1'b1, 8'h3F},
        '{KIND_WRITE,   14'h3F1F, 8'hC5, 1'b1, 8'h00},
        '{KIND_READ,    14'h3FFF, 8'h00, 1'b1, 8'h05},
        '{KIND_PRELOAD, 14'h2C01, 8'h5A, 1'b1, 8'h00},  // preload off the pattern store writes
        '{KIND_READ,    14'h2801, 8'h00, 1'b0, 8'h00},
        '{KIND_WRITE,   14'h3EFF, 8'h77, 1'b1, 8'h00},  // top of the 0x3000 mirror region
        '{KIND_READ,    14'h2EFF, 8'h00, 1'b0, 8'h00},
        '{KIND_PRELOAD, 14'h3F1C, 8'h2A, 1'b1, 8'h00},
        '{KIND_READ,    14'h3F0C, 8'h00, 1'b0, 8'h00}
    };

    logic clk;
    logic rst_n;
    logic                  cfg_we;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;

    vmm_access_if access_ch ();
    vmm_result_if result_ch ();

    video_memory_map_mirroring_top i_dut
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .access    (access_ch),
        .result    (result_ch),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    // predictor state
    logic [DATA_W-1:0] pattern_mem   [PATTERN_BYTES];
    logic [DATA_W-1:0] nametable_mem [NT_BYTES];
    logic [PAL_W-1:0]  palette_mem   [PAL_ENTRIES];
    logic [1:0]        mirror_sel;
    logic              pattern_is_ram;

    // stimulus-side record of pattern bytes that hold a value, so reads stay defined
    bit pattern_filled [PATTERN_BYTES];
    int pattern_known [$];

    logic [DATA_W-1:0] read_data_due [$];
    access_row_t       typed_answers [$];

    bit hold_request;
    int errors;
    int idle_cycles;
    int n_reads, n_writes, n_preloads, n_results;

    always #1 clk = ~clk;

    // works out the result byte of one access and applies its side effects
    function automatic logic [DATA_W-1:0] serve_access(input logic [1:0] kind,
                                                       input logic [ADDR_W-1:0] addr,
                                                       input logic [DATA_W-1:0] data);
        logic              stores;
        logic [11:0]       rel;
        logic [NT_AW-1:0]  slot;
        logic [PAL_AW-1:0] entry;
        logic [DATA_W-1:0] rd;

        stores = (kind == KIND_WRITE) || (kind == KIND_PRELOAD);
        rd = '0;
        if (addr < 14'h2000)
        begin
            if (!stores)
                rd = pattern_mem[addr[PAT_AW-1:0]];
            else if (kind == KIND_PRELOAD || pattern_is_ram)
                pattern_mem[addr[PAT_AW-1:0]] = data;
        end
        else if (addr < 14'h3F00)
        begin
            // offset from 0x2000 within the 4 KB nametable window
            rel = addr[11:0];
            case (mirror_sel)
                MIRROR_FOUR_SCREEN: slot = rel[10:0];
                MIRROR_HORIZONTAL:  slot = {rel[11], rel[9:0]};
                default:            slot = {rel[10], rel[9:0]};  // vertical, also mode 3
            endcase
            if (stores)
                nametable_mem[slot] = data;
            else
                rd = nametable_mem[slot];
        end
        else
        begin
            entry = addr[PAL_AW-1:0];
            // backdrop mirrors: 0x10, 0x14, 0x18, 0x1c fold onto 0x00..0x0c
            if (entry[4] && entry[1:0] == 2'b00)
                entry[4] = 1'b0;
            if (stores)
                palette_mem[entry] = data[PAL_W-1:0];
            else
                rd = {2'b00, palette_mem[entry]};
        end
        return rd;
    endfunction

    // offers one access beat and returns at the edge that takes it
    task automatic send_beat(input logic [1:0] kind, input logic [ADDR_W-1:0] addr,
                             input logic [DATA_W-1:0] data, input logic pinned,
                             input logic [DATA_W-1:0] answer);
        access_row_t note;

        note = '{kind, addr, data, pinned, answer};
        typed_answers.push_back(note);
        if (addr < 14'h2000 && !pattern_filled[addr[PAT_AW-1:0]]
            && (kind == KIND_PRELOAD || (kind == KIND_WRITE && pattern_is_ram)))
        begin
            pattern_filled[addr[PAT_AW-1:0]] = 1'b1;
            pattern_known.push_back(int'(addr));
        end
        access_ch.valid      <= 1'b1;
        access_ch.kind       <= kind;
        access_ch.address    <= addr;
        access_ch.write_data <= data;
        @(posedge clk);
        while (!access_ch.ready)
            @(posedge clk);
    endtask

    // map settings change only with the pipe drained
    task automatic set_map_config(input logic [1:0] mirror, input logic writable);
        while (read_data_due.size() != 0 || typed_answers.size() != 0)
            @(posedge clk);
        repeat (SETTLE) @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= CFG_MIRROR_MODE;
        cfg_data  <= mirror;
        @(posedge clk);
        cfg_index <= CFG_PATTERN_WRITABLE;
        cfg_data  <= {1'b0, writable};
        @(posedge clk);
        cfg_we <= 1'b0;
        mirror_sel     = mirror;
        pattern_is_ram = writable;
    endtask

    // beat monitor: predict at acceptance, check results in order
    always @(posedge clk)
    begin
        access_row_t       note;
        logic [DATA_W-1:0] predicted;
        logic [DATA_W-1:0] due;

        if (rst_n && access_ch.valid && access_ch.ready)
        begin
            predicted = serve_access(access_ch.kind, access_ch.address, access_ch.write_data);
            note = typed_answers.pop_front();
            read_data_due.push_back(note.pinned ? note.answer : predicted);
            case (access_ch.kind)
                KIND_WRITE:   n_writes++;
                KIND_PRELOAD: n_preloads++;
                default:      n_reads++;
            endcase
        end
        if (rst_n && result_ch.valid && result_ch.ready)
        begin
            n_results++;
            if (read_data_due.size() == 0)
            begin
                $error("read_data beat with nothing due: got %0h", result_ch.read_data);
                errors++;
            end
            else
            begin
                due = read_data_due.pop_front();
                if (result_ch.read_data !== due)
                begin
                    $error("read_data mismatch: expected %0h, actual %0h",
                           due, result_ch.read_data);
                    errors++;
                end
            end
        end
    end

    // watchdog: too long without any beat on either channel
    always @(posedge clk)
    begin
        if (!rst_n || (access_ch.valid && access_ch.ready)
            || (result_ch.valid && result_ch.ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= IDLE_LIMIT)
        begin
            $display("watchdog: no beat for %0d cycles, %0d results outstanding",
                     idle_cycles, read_data_due.size());
            $display("TEST FAILED");
            $finish;
        end
    end

    // result side: changing stall styles, plus one long hold-off on request
    initial
    begin
        int style;
        int step;

        result_ch.ready <= 1'b0;
        wait (rst_n === 1'b1);
        forever
        begin
            style = $urandom_range(0, 3);
            for (step = 0; step < 48; step++)
            begin
                if (hold_request)
                begin
                    result_ch.ready <= 1'b0;
                    repeat (HOLD_CYCLES) @(posedge clk);
                    hold_request = 1'b0;
                end
                case (style)
                    0:       result_ch.ready <= 1'b1;
                    1:       result_ch.ready <= STALL_PATTERN[step % 11];
                    2:       result_ch.ready <= ($urandom_range(0, 3) != 0);
                    default: result_ch.ready <= 1'($urandom_range(0, 1));
                endcase
                @(posedge clk);
            end
        end
    end

    // access side: reset, directed rows, then random phases
    initial
    begin
        int                row;
        int                phase;
        int                sent;
        int                burst;
        int                gap;
        int                pick;
        logic [1:0]        kind;
        logic [ADDR_W-1:0] addr;
        logic [11:0]       rel;
        logic [9:0]        offset;

        clk            = 1'b0;
        rst_n          = 1'b0;
        hold_request   = 1'b0;
        errors         = 0;
        n_reads        = 0;
        n_writes       = 0;
        n_preloads     = 0;
        n_results      = 0;
        mirror_sel     = MIRROR_HORIZONTAL;
        pattern_is_ram = 1'b0;
        foreach (nametable_mem[i]) nametable_mem[i] = '0;
        foreach (palette_mem[i]) palette_mem[i] = '0;
        foreach (pattern_mem[i]) pattern_mem[i] = '0;
        access_ch.valid      <= 1'b0;
        access_ch.kind       <= KIND_READ;
        access_ch.address    <= '0;
        access_ch.write_data <= '0;
        cfg_we               <= 1'b0;
        cfg_index            <= CFG_MIRROR_MODE;
        cfg_data             <= '0;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;

        // directed rows, back to back
        set_map_config(MIRROR_HORIZONTAL, 1'b0);
        for (row = 0; row < DIRECTED_ROWS; row++)
            send_beat(DIRECTED[row].kind, DIRECTED[row].addr, DIRECTED[row].data,
                      DIRECTED[row].pinned, DIRECTED[row].answer);
        access_ch.valid <= 1'b0;

        for (phase = 0; phase < PHASES; phase++)
        begin
            set_map_config(PHASE_MIRROR[phase], PHASE_WRITABLE[phase]);
            // receiver sits still while beats keep coming, so the pipe backs up
            if (phase == HOLD_PHASE)
                hold_request = 1'b1;
            sent = 0;
            while (sent < PER_PHASE)
            begin
                burst = $urandom_range(1, 24);
                for (int k = 0; k < burst && sent < PER_PHASE; k++)
                begin
                    pick = $urandom_range(0, 99);
                    if (pick < 45)
                        kind = KIND_READ;
                    else if (pick < 72)
                        kind = KIND_WRITE;
                    else if (pick < 92)
                        kind = KIND_PRELOAD;
                    else
                        kind = KIND_SPARE;

                    pick = $urandom_range(0, 99);
                    if (pick < 30)
                    begin
                        // pattern store: reads only where a value was stored
                        if (kind == KIND_READ || kind == KIND_SPARE)
                        begin
                            if (pattern_known.size() == 0)
                            begin
                                kind = KIND_PRELOAD;
                                addr = 14'($urandom_range(0, 14'h1FFF));
                            end
                            else
                                addr = 14'(pattern_known[$urandom_range(0,
                                                         pattern_known.size() - 1)]);
                        end
                        else if (pattern_known.size() != 0 && $urandom_range(0, 1))
                            addr = 14'(pattern_known[$urandom_range(0,
                                                     pattern_known.size() - 1)]);
                        else
                            addr = 14'($urandom_range(0, 14'h1FFF));
                    end
                    else if (pick < 75)
                    begin
                        // nametable: a few hot offsets so mirrored aliases collide
                        if ($urandom_range(0, 9) < 3)
                            offset = 10'($urandom_range(0, 1023));
                        else
                            offset = 10'($urandom_range(0, 7) * 'h83);
                        rel = {2'($urandom_range(0, 3)), offset};
                        addr = 14'h2000 + {2'b00, rel};
                        // upper copy of the window, stopping short of the palette
                        if (rel < 12'hF00 && $urandom_range(0, 1))
                            addr = addr + 14'h1000;
                    end
                    else
                        addr = 14'h3F00 | 14'($urandom_range(0, 7) << 5)
                               | 14'($urandom_range(0, 31));
                    send_beat(kind, addr, 8'($urandom_range(0, 255)), 1'b0, 8'h00);
                    sent++;
                end
                gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
                if (gap > 0)
                begin
                    access_ch.valid <= 1'b0;
                    repeat (gap) @(posedge clk);
                end
            end
            access_ch.valid <= 1'b0;
        end

        // drain, then let the pipe settle
        while (read_data_due.size() != 0 || typed_answers.size() != 0)
            @(posedge clk);
        repeat (SETTLE) @(posedge clk);

        $display("covered %0d accesses: %0d reads, %0d writes, %0d preloads, %0d results",
                 n_reads + n_writes + n_preloads, n_reads, n_writes, n_preloads, n_results);
        $display("map settings: all four mirror modes, pattern store ram and rom, one long stall");
        if (errors == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule
